### hdl/utbl_pkg.sv
// Package for the unique key list table: request and response item types,
// opcode and status codes. No dependencies.
package utbl_pkg;

   localparam int KEY_W   = 32;
   localparam int VAL_W   = 32;
   localparam int OP_W    = 2;
   localparam int STAT_W  = 2;
   localparam int FIELD_W = 4;

   localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
   localparam logic [OP_W-1:0] OP_LOOKUP = 2'd1;
   localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

   localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
   localparam logic [STAT_W-1:0] STAT_DUP  = 2'd1;
   localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;
   localparam logic [STAT_W-1:0] STAT_MISS = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0]         opcode;
      logic signed [KEY_W-1:0] search_key;
      logic signed [VAL_W-1:0] entry_value;
   } req_type;

   typedef struct packed {
      logic [STAT_W-1:0]       status;
      logic [FIELD_W-1:0]      position;
      logic signed [VAL_W-1:0] found_value;
      logic [FIELD_W-1:0]      entry_count;
   } rsp_type;

   // A finished item handed from the sequencer to the output register.
   typedef struct packed {
      logic    vld;
      rsp_type rsp;
   } fin_type;

endpackage

### hdl/utbl_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module utbl_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 8,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### hdl/utbl_seq.sv
// Sequencer of the unique key list table: scans the entry RAM with one
// shared key comparator and moves entries down after a remove. Uses utbl_pkg.
module utbl_seq #(
   parameter int DEPTH = 8,
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W = $clog2(DEPTH + 1),
   localparam int ENT_W = utbl_pkg::KEY_W + utbl_pkg::VAL_W
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  utbl_pkg::req_type req_item,
   output logic              busy,
   output logic              wr_en,
   output logic [IDX_W-1:0]  wr_addr,
   output logic [ENT_W-1:0]  wr_data,
   output logic              rd_en,
   output logic [IDX_W-1:0]  rd_addr,
   input  logic [ENT_W-1:0]  rd_data,
   output utbl_pkg::fin_type fin
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_SCAN  = 2'd1;
   localparam logic [1:0] ST_SHIFT = 2'd2;

   logic [1:0]                      state_ff, state_in;
   logic [utbl_pkg::OP_W-1:0]       op_ff, op_in;
   logic [utbl_pkg::KEY_W-1:0]      key_ff, key_in;
   logic [utbl_pkg::VAL_W-1:0]      val_ff, val_in;
   logic [utbl_pkg::VAL_W-1:0]      fval_ff, fval_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic [CNT_W-1:0]                issue_ff, issue_in;
   logic                            cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]                cmp_idx_ff, cmp_idx_in;
   logic [utbl_pkg::KEY_W-1:0]      rd_key;
   logic [utbl_pkg::VAL_W-1:0]      rd_val;
   logic                            hit;
   logic                            more;

   assign rd_key = rd_data[ENT_W-1:utbl_pkg::VAL_W];
   assign rd_val = rd_data[utbl_pkg::VAL_W-1:0];
   assign hit    = cmp_vld_ff && (rd_key == key_ff);
   assign more   = issue_ff < count_ff;
   assign busy   = state_ff != ST_IDLE;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      key_in     = key_ff;
      val_in     = val_ff;
      fval_in    = fval_ff;
      count_in   = count_ff;
      issue_in   = issue_ff;
      cmp_vld_in = 1'b0;
      cmp_idx_in = cmp_idx_ff;
      rd_en      = 1'b0;
      rd_addr    = issue_ff[IDX_W-1:0];
      wr_en      = 1'b0;
      wr_addr    = count_ff[IDX_W-1:0];
      wr_data    = {key_ff, val_ff};
      fin        = '0;
      fin.rsp.entry_count = 4'(count_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               op_in    = req_item.opcode;
               key_in   = req_item.search_key;
               val_in   = req_item.entry_value;
               issue_in = '0;
               case (req_item.opcode) inside
                  utbl_pkg::OP_INSERT: begin
                     if (count_ff == CNT_W'(DEPTH)) begin
                        fin.vld        = 1'b1;
                        fin.rsp.status = utbl_pkg::STAT_FULL;
                     end else begin
                        state_in = ST_SCAN;
                     end
                  end
                  utbl_pkg::OP_LOOKUP, utbl_pkg::OP_REMOVE: begin
                     state_in = ST_SCAN;
                  end
                  default: begin
                     // Unused opcode: acknowledged with no effect.
                     fin.vld        = 1'b1;
                     fin.rsp.status = utbl_pkg::STAT_OK;
                  end
               endcase
            end
         end

         ST_SCAN: begin
            if (hit) begin
               case (op_ff)
                  utbl_pkg::OP_LOOKUP: begin
                     fin.vld          = 1'b1;
                     fin.rsp.position = 4'(cmp_idx_ff);
                     state_in         = ST_IDLE;
                  end
                  utbl_pkg::OP_REMOVE: begin
                     fval_in  = rd_val;
                     state_in = ST_SHIFT;
                  end
                  default: begin
                     fin.vld        = 1'b1;
                     fin.rsp.status = utbl_pkg::STAT_DUP;
                     state_in       = ST_IDLE;
                  end
               endcase
            end else if (more) begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + CNT_W'(1);
            end else begin
               fin.vld  = 1'b1;
               state_in = ST_IDLE;
               if (op_ff == utbl_pkg::OP_INSERT) begin
                  // Key absent: append at the end of the list.
                  wr_en               = 1'b1;
                  count_in            = count_ff + CNT_W'(1);
                  fin.rsp.position    = 4'(count_ff + CNT_W'(1));
                  fin.rsp.entry_count = 4'(count_ff + CNT_W'(1));
               end else begin
                  fin.rsp.status = utbl_pkg::STAT_MISS;
               end
            end
         end

         ST_SHIFT: begin
            // Entry read last cycle moves down one place.
            if (cmp_vld_ff) begin
               wr_en   = 1'b1;
               wr_addr = cmp_idx_ff - IDX_W'(1);
               wr_data = rd_data;
            end
            if (more) begin
               rd_en      = 1'b1;
               cmp_vld_in = 1'b1;
               cmp_idx_in = issue_ff[IDX_W-1:0];
               issue_in   = issue_ff + CNT_W'(1);
            end else if (!cmp_vld_ff) begin
               count_in            = count_ff - CNT_W'(1);
               fin.vld             = 1'b1;
               fin.rsp.found_value = fval_ff;
               fin.rsp.entry_count = 4'(count_ff - CNT_W'(1));
               state_in            = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         count_ff   <= '0;
         cmp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         count_ff   <= count_in;
         cmp_vld_ff <= cmp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      key_ff     <= key_in;
      val_ff     <= val_in;
      fval_ff    <= fval_in;
      issue_ff   <= issue_in;
      cmp_idx_ff <= cmp_idx_in;
   end

endmodule

### hdl/unique_key_list_table_top.sv
// Top level of the unique key list table: sequencer, entry RAM and the
// response register. Uses utbl_pkg, utbl_seq and utbl_ram.
//
// The block keeps an unordered, compacted list of up to DEPTH key/value
// entries. An item is accepted when start is high while busy is low, and
// busy then stays high until the item is done. Insert appends a new key
// (full is checked first, then duplicates), lookup gives the index of the
// key, and remove returns its value and closes the gap. Every item gives
// exactly one response, shown on rsp_item for a single cycle with
// rsp_strobe high; the receiver cannot stall it, so it must take the item
// in that cycle. Entries live in one RAM with a registered read port, and a
// single key comparator walks it one entry per cycle with reads overlapped
// with compares. A lookup, a remove search or an insert scans the entries held
// in order and stops early on a hit; a remove then moves the later entries
// down at one entry per cycle. An insert into a full list and the unused
// opcode finish in the accepting cycle. The response is registered and
// appears in the cycle after the item finishes, and a new item may be
// accepted in that same cycle.
module unique_key_list_table_top #(
   parameter int DEPTH = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  utbl_pkg::req_type req_item,
   output logic              busy,
   output logic              rsp_strobe,
   output utbl_pkg::rsp_type rsp_item
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int ENT_W = utbl_pkg::KEY_W + utbl_pkg::VAL_W;

   logic              wr_en;
   logic [IDX_W-1:0]  wr_addr;
   logic [ENT_W-1:0]  wr_data;
   logic              rd_en;
   logic [IDX_W-1:0]  rd_addr;
   logic [ENT_W-1:0]  rd_data;
   utbl_pkg::fin_type fin;

   logic              rsp_strobe_ff, rsp_strobe_in;
   utbl_pkg::rsp_type rsp_item_ff, rsp_item_in;

   utbl_seq #(
      .DEPTH (DEPTH)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .req_item (req_item),
      .busy     (busy),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_en    (rd_en),
      .rd_addr  (rd_addr),
      .rd_data  (rd_data),
      .fin      (fin)
   );

   // Key in the upper half of each word, value in the lower half.
   utbl_ram #(
      .WIDTH (ENT_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Response register: the strobe lasts exactly one cycle per item.
   assign rsp_strobe_in = fin.vld;
   assign rsp_item_in   = fin.vld ? fin.rsp : rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`ifndef SYNTH
   // The list is only ever changed while an item is in progress.
   a_write_only_busy: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> busy)
      else $error("entry RAM written while idle");

   // Shifting never reads the entry that is being overwritten.
   a_no_rw_collision: assert property (@(posedge clock) disable iff (reset)
      (wr_en && rd_en) |-> (wr_addr != rd_addr))
      else $error("entry RAM read and written at the same address");

   // A lookup always goes through the scan, so it cannot finish at once.
   a_lookup_scans: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.opcode == utbl_pkg::OP_LOOKUP) |=> busy)
      else $error("lookup finished without a scan");
`endif

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the unique key list table (unique_key_list_table_top).
// Depends on utbl_pkg for the item types and codes, and on the RTL under hdl/.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   // Size of the list under test, and the opcode that the block must ignore.
   localparam int DEPTH = 8;
   localparam logic [utbl_pkg::OP_W-1:0] OP_UNUSED = 2'd3;

   // The watchdog gives up after this many cycles in which no item was taken
   // and no response came. The slowest item is a remove at the head of a full
   // list; the limit leaves a wide margin over it and over the longest sender gap.
   localparam int IDLE_LIMIT = 2000;
   // Cycles of quiet observed after the last response, to catch stray strobes.
   localparam int TAIL_CYCLES = 40;
   // Number of counted random items; the unused opcode does not count.
   localparam int RANDOM_ITEMS = 800;
   localparam int POOL_SIZE = 12;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   utbl_pkg::req_type req_item = '0;
   logic              busy;
   logic              rsp_strobe;
   utbl_pkg::rsp_type rsp_item;

   unique_key_list_table_top #(
      .DEPTH(DEPTH)
   ) u_dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .req_item(req_item),
      .busy(busy),
      .rsp_strobe(rsp_strobe),
      .rsp_item(rsp_item)
   );

   always #1 clock = ~clock;

   // One row of the directed table. Rows with pinned set carry a response
   // typed in by hand; the others are checked against the list model below.
   typedef struct {
      utbl_pkg::req_type req;
      bit                pinned;
      utbl_pkg::rsp_type rsp;
   } row_type;

   row_type directed_rows[$];

   // Responses still owed by the block, oldest first.
   utbl_pkg::rsp_type awaited_rsps[$];
   int                error_count = 0;

   // The testbench's own copy of the list: keys, values and the count.
   logic signed [utbl_pkg::KEY_W-1:0] held_keys [DEPTH];
   logic signed [utbl_pkg::VAL_W-1:0] held_vals [DEPTH];
   int                                held_count = 0;

   // Sender pacing: the number of items left in the current burst.
   int burst_left = 0;

   // Applies one item to the list model and returns the response it causes.
   // Only entries below the count are compared or read, so a never-written
   // slot is never touched.
   function automatic utbl_pkg::rsp_type table_outcome(input utbl_pkg::req_type it);
      utbl_pkg::rsp_type r;
      int                hit;
      int                i;
      r = '0;
      hit = -1;
      for (i = 0; i < held_count; i++) begin
         if (hit < 0 && held_keys[i] == it.search_key) begin
            hit = i;
         end
      end
      case (it.opcode)
         utbl_pkg::OP_INSERT: begin
            // Fullness wins over the duplicate test.
            if (held_count >= DEPTH) begin
               r.status = utbl_pkg::STAT_FULL;
            end else if (hit >= 0) begin
               r.status = utbl_pkg::STAT_DUP;
            end else begin
               held_keys[held_count] = it.search_key;
               held_vals[held_count] = it.entry_value;
               held_count++;
               r.position = utbl_pkg::FIELD_W'(held_count);
            end
         end
         utbl_pkg::OP_LOOKUP: begin
            if (hit < 0) begin
               r.status = utbl_pkg::STAT_MISS;
            end else begin
               r.position = utbl_pkg::FIELD_W'(hit);
            end
         end
         utbl_pkg::OP_REMOVE: begin
            if (hit < 0) begin
               r.status = utbl_pkg::STAT_MISS;
            end else begin
               r.found_value = held_vals[hit];
               // Close the gap by moving every later entry down one place.
               for (i = hit; i + 1 < held_count; i++) begin
                  held_keys[i] = held_keys[i + 1];
                  held_vals[i] = held_vals[i + 1];
               end
               held_count--;
            end
         end
         default: begin
            // The unused opcode leaves the list alone and reports ok.
         end
      endcase
      r.entry_count = utbl_pkg::FIELD_W'(held_count);
      return r;
   endfunction

   // Prints one line for a failure and counts it.
   task automatic report_error(input string msg);
      $display("[%0t] ERROR: %s", $realtime, msg);
      error_count++;
   endtask

   task automatic add_row(input logic [utbl_pkg::OP_W-1:0] op,
                          input logic [utbl_pkg::KEY_W-1:0] key,
                          input logic [utbl_pkg::VAL_W-1:0] val, input bit pinned,
                          input logic [utbl_pkg::STAT_W-1:0] st,
                          input logic [utbl_pkg::FIELD_W-1:0] pos,
                          input logic [utbl_pkg::VAL_W-1:0] fval,
                          input logic [utbl_pkg::FIELD_W-1:0] cnt);
      row_type row;
      row.req.opcode      = op;
      row.req.search_key  = key;
      row.req.entry_value = val;
      row.pinned          = pinned;
      row.rsp.status      = st;
      row.rsp.position    = pos;
      row.rsp.found_value = fval;
      row.rsp.entry_count = cnt;
      directed_rows.push_back(row);
   endtask

   // Sender pacing. Items go out in bursts of random length; between bursts
   // start drops for a random gap, so gaps land on every phase of the
   // block's scan and shift.
   task automatic pace_sender();
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 12);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      burst_left--;
   endtask

   // Presents one item and returns at the edge that takes it. At that edge
   // the model is stepped and the owed response is queued; start stays high,
   // so the caller either presents the next item in this same step or drops
   // start. The response of the previous item may be checked at this edge
   // too, which is harmless because it sits at the front of the queue.
   task automatic issue_item(input utbl_pkg::req_type it, input bit pinned,
                             input utbl_pkg::rsp_type fixed_rsp);
      utbl_pkg::rsp_type predicted;
      start    <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy) @(posedge clock);
      predicted = table_outcome(it);
      awaited_rsps.push_back(pinned ? fixed_rsp : predicted);
   endtask

   // Sender pause: start drops and nothing is sent until every owed response
   // has come back.
   task automatic wait_all_returned();
      start <= 1'b0;
      @(posedge clock);
      while (awaited_rsps.size() != 0) @(posedge clock);
   endtask

   // Response checker. Values are read at the rising edge, before the block's
   // own updates at that edge take effect, so a strobe seen here marks the
   // cycle that this edge ends.
   always @(posedge clock) begin
      utbl_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (awaited_rsps.size() == 0) begin
            report_error($sformatf("response with no item outstanding: %p", rsp_item));
         end else begin
            want = awaited_rsps.pop_front();
            if (rsp_item.status !== want.status)
               report_error($sformatf("status got %0d want %0d",
                                      rsp_item.status, want.status));
            if (rsp_item.position !== want.position)
               report_error($sformatf("position got %0d want %0d",
                                      rsp_item.position, want.position));
            if (rsp_item.found_value !== want.found_value)
               report_error($sformatf("found_value got %h want %h",
                                      rsp_item.found_value, want.found_value));
            if (rsp_item.entry_count !== want.entry_count)
               report_error($sformatf("entry_count got %0d want %0d",
                                      rsp_item.entry_count, want.entry_count));
         end
      end
   end

   // Watchdog: counts cycles in which no item was taken and no response came.
   // Reaching the limit means the block hung or a response went missing.
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (start && !busy) || rsp_strobe) begin
            idle_cycles = 0;
         end else begin
            idle_cycles++;
         end
      end
      $display("watchdog: no progress for %0d cycles", IDLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   // Stimulus: the directed table first, then random phases that fill and
   // drain the list around a small pool of keys, so that hits, duplicates,
   // a full list and an empty list all come up often.
   initial begin
      logic [utbl_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
      utbl_pkg::req_type          it;
      utbl_pkg::rsp_type          none;
      int                         counted;
      int                         phase_left;
      int                         insert_pct;
      int                         remove_pct;
      int                         roll;
      bit                         paused;
      int                         i;

      none = '0;

      // After reset the list is empty, so every search misses.
      add_row(utbl_pkg::OP_LOOKUP, 32'h0000_0000, 32'h0000_0000, 1,
              utbl_pkg::STAT_MISS, 0, 0, 0);
      add_row(utbl_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 1,
              utbl_pkg::STAT_MISS, 0, 0, 0);
      add_row(OP_UNUSED, 32'h7fff_ffff, 32'hffff_ffff, 1, utbl_pkg::STAT_OK, 0, 0, 0);
      // Fill the list, with the key extremes among the entries.
      add_row(utbl_pkg::OP_INSERT, 32'h8000_0000, 32'h7fff_ffff, 1,
              utbl_pkg::STAT_OK, 1, 0, 1);
      add_row(utbl_pkg::OP_INSERT, 32'h7fff_ffff, 32'h8000_0000, 1,
              utbl_pkg::STAT_OK, 2, 0, 2);
      add_row(utbl_pkg::OP_INSERT, 32'h8000_0000, 32'h0000_0005, 1,
              utbl_pkg::STAT_DUP, 0, 0, 2);
      add_row(utbl_pkg::OP_INSERT, 32'h0000_0000, 32'h0000_0000, 1,
              utbl_pkg::STAT_OK, 3, 0, 3);
      add_row(utbl_pkg::OP_INSERT, 32'hffff_ffff, 32'hffff_ffff, 1,
              utbl_pkg::STAT_OK, 4, 0, 4);
      add_row(utbl_pkg::OP_INSERT, 32'h0000_0001, 32'ha5a5_a5a5, 1,
              utbl_pkg::STAT_OK, 5, 0, 5);
      add_row(utbl_pkg::OP_INSERT, 32'h0000_0002, 32'h5a5a_5a5a, 1,
              utbl_pkg::STAT_OK, 6, 0, 6);
      add_row(utbl_pkg::OP_INSERT, 32'h0000_0003, 32'h1234_5678, 1,
              utbl_pkg::STAT_OK, 7, 0, 7);
      add_row(utbl_pkg::OP_INSERT, 32'h0000_0004, 32'hfedc_ba98, 1,
              utbl_pkg::STAT_OK, 8, 0, 8);
      // A full list refuses a new key, and also a key already present.
      add_row(utbl_pkg::OP_INSERT, 32'h0000_0005, 32'h0000_0001, 1,
              utbl_pkg::STAT_FULL, 0, 0, 8);
      add_row(utbl_pkg::OP_INSERT, 32'h8000_0000, 32'h0000_0001, 1,
              utbl_pkg::STAT_FULL, 0, 0, 8);
      add_row(utbl_pkg::OP_LOOKUP, 32'h8000_0000, 32'h0000_0000, 1,
              utbl_pkg::STAT_OK, 0, 0, 8);
      add_row(utbl_pkg::OP_LOOKUP, 32'h0000_0004, 32'h0000_0000, 1,
              utbl_pkg::STAT_OK, 7, 0, 8);
      add_row(utbl_pkg::OP_LOOKUP, 32'h0000_0063, 32'h0000_0000, 1,
              utbl_pkg::STAT_MISS, 0, 0, 8);
      add_row(OP_UNUSED, 32'h0000_0004, 32'h0000_0000, 1, utbl_pkg::STAT_OK, 0, 0, 8);
      // Removing the head shifts every entry down.
      add_row(utbl_pkg::OP_REMOVE, 32'h8000_0000, 32'h0000_0000, 1,
              utbl_pkg::STAT_OK, 0, 32'h7fff_ffff, 7);
      add_row(utbl_pkg::OP_LOOKUP, 32'h7fff_ffff, 32'h0000_0000, 0, 0, 0, 0, 0);
      add_row(utbl_pkg::OP_REMOVE, 32'h0000_0004, 32'h0000_0000, 0, 0, 0, 0, 0);
      add_row(utbl_pkg::OP_REMOVE, 32'h0000_0063, 32'h0000_0000, 1,
              utbl_pkg::STAT_MISS, 0, 0, 6);
      add_row(utbl_pkg::OP_LOOKUP, 32'hffff_ffff, 32'h0000_0000, 0, 0, 0, 0, 0);
      add_row(utbl_pkg::OP_REMOVE, 32'h0000_0000, 32'h0000_0000, 0, 0, 0, 0, 0);
      add_row(utbl_pkg::OP_INSERT, 32'h8000_0000, 32'h0f0f_0f0f, 0, 0, 0, 0, 0);

      // Synchronous reset, held high at the start and never raised again.
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[n]) begin
         pace_sender();
         issue_item(directed_rows[n].req, directed_rows[n].pinned, directed_rows[n].rsp);
      end

      // Let everything settle once before the random part starts.
      wait_all_returned();

      counted    = 0;
      phase_left = 0;
      paused     = 0;
      insert_pct = 50;
      remove_pct = 25;
      while (counted < RANDOM_ITEMS) begin
         if (phase_left == 0) begin
            // A new phase: fresh key pool and a new mix that leans toward
            // filling, draining or neither.
            phase_left = $urandom_range(30, 60);
            for (i = 0; i < POOL_SIZE; i++) begin
               case ($urandom_range(0, 9))
                  0:       key_pool[i] = 32'h8000_0000;
                  1:       key_pool[i] = 32'h7fff_ffff;
                  2:       key_pool[i] = $urandom_range(0, 3);
                  default: key_pool[i] = $urandom;
               endcase
            end
            case ($urandom_range(0, 2))
               0: begin
                  insert_pct = 65;
                  remove_pct = 15;
               end
               1: begin
                  insert_pct = 20;
                  remove_pct = 55;
               end
               default: begin
                  insert_pct = 40;
                  remove_pct = 35;
               end
            endcase
         end
         phase_left--;

         roll = $urandom_range(0, 99);
         if (roll < 4) begin
            it.opcode = OP_UNUSED;
         end else if (roll < 4 + insert_pct) begin
            it.opcode = utbl_pkg::OP_INSERT;
         end else if (roll < 4 + insert_pct + remove_pct) begin
            it.opcode = utbl_pkg::OP_REMOVE;
         end else begin
            it.opcode = utbl_pkg::OP_LOOKUP;
         end
         // Mostly keys from the pool so that searches hit; some noise keys.
         if ($urandom_range(0, 99) < 85) begin
            it.search_key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
         end else begin
            it.search_key = $urandom;
         end
         it.entry_value = $urandom;

         pace_sender();
         issue_item(it, 0, none);
         if (it.opcode != OP_UNUSED) begin
            counted++;
         end

         // Once, halfway through, the sender waits for every response.
         if (!paused && counted >= RANDOM_ITEMS / 2) begin
            paused = 1;
            wait_all_returned();
         end
      end

      // Drain: nothing more is sent; wait for the last responses, then watch
      // a while longer for any stray strobe.
      wait_all_returned();
      repeat (TAIL_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### unique_key_list_table_top.f
hdl/utbl_pkg.sv
hdl/utbl_ram.sv
hdl/utbl_seq.sv
hdl/unique_key_list_table_top.sv
tb/sv/tb.sv
